// ----- sv/cdf_pkg.sv -----
// Package for the complex decimating FIR: shared types, codes and fixed widths.
// No dependencies; every other file of the block imports it.
package cdf_pkg;

    localparam int SMP_W      = 16;
    localparam int COEF_W     = 16;
    localparam int PROD_W     = 32;
    localparam int RES_W      = 38;
    localparam int IDX_W      = 6;
    localparam int TAP_CNT_W  = 7;
    localparam int DECIM_W    = 11;
    localparam int PHASE_W    = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    localparam logic [TAP_CNT_W-1:0] TAP_CNT_RST = 7'd64;
    localparam logic [DECIM_W-1:0]   DECIM_RST   = 11'd1;
    localparam logic [DECIM_W-1:0]   DECIM_MAX   = 11'd1024;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECIMATION = 1'd1;

    // Input word opcodes.
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PASS,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic signed [SMP_W-1:0] i;
        logic signed [SMP_W-1:0] q;
    } t_iq;

    typedef struct packed {
        logic shift;
        logic rot_smp;
        logic rot_coef;
    } t_cell_ctl;

endpackage

// ----- sv/cdf_in_if.sv -----
// Input channel of the complex decimating FIR: valid/ready plus one input word.
// Depends on cdf_pkg for the field widths.
interface cdf_in_if;
    import cdf_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     opcode;
    logic [IDX_W-1:0]         coeff_index;
    logic signed [COEF_W-1:0] coeff_value;
    logic signed [SMP_W-1:0]  sample_i;
    logic signed [SMP_W-1:0]  sample_q;
    logic                     block_start;

    modport source (
        output valid, opcode, coeff_index, coeff_value, sample_i, sample_q, block_start,
        input  ready
    );

    modport sink (
        input  valid, opcode, coeff_index, coeff_value, sample_i, sample_q, block_start,
        output ready
    );
endinterface

// ----- sv/cdf_out_if.sv -----
// Output channel of the complex decimating FIR: valid/ready plus one result word.
// Depends on cdf_pkg for the field widths.
interface cdf_out_if;
    import cdf_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [RES_W-1:0] result_i;
    logic signed [RES_W-1:0] result_q;

    modport source (
        output valid, result_i, result_q,
        input  ready
    );

    modport sink (
        input  valid, result_i, result_q,
        output ready
    );
endinterface

// ----- sv/cdf_sample_cell.sv -----
// One delay-line cell holding an I/Q sample pair.
// Depends on cdf_pkg for t_iq and t_cell_ctl.
module cdf_sample_cell
    import cdf_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_iq       i_prev,
    input  t_iq       i_next,
    output t_iq       o_smp
);

    t_iq r_smp;

    // New samples enter from the previous cell; during a sum pass the ring turns
    // the other way so every sample reaches cell zero once.
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_smp <= i_prev;
        end else if (i_ctl.rot_smp) begin
            r_smp <= i_next;
        end
    end

    assign o_smp = r_smp;

endmodule

// ----- sv/cdf_coef_cell.sv -----
// One coefficient ring cell: loaded by its own write enable, rotates during a pass.
// Depends on cdf_pkg for COEF_W and t_cell_ctl.
module cdf_coef_cell
    import cdf_pkg::*;
(
    input  logic                     i_clk,
    input  t_cell_ctl                i_ctl,
    input  logic                     i_load,
    input  logic signed [COEF_W-1:0] i_load_value,
    input  logic signed [COEF_W-1:0] i_prev,
    output logic signed [COEF_W-1:0] o_coef
);

    logic signed [COEF_W-1:0] r_coef;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_coef <= i_load_value;
        end else if (i_ctl.rot_coef) begin
            r_coef <= i_prev;
        end
    end

    assign o_coef = r_coef;

endmodule

// ----- sv/cdf_mac.sv -----
// Complex multiply-accumulate unit fed from the head cells of both rings.
// Depends on cdf_pkg for widths and t_iq.
module cdf_mac
    import cdf_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_clear,
    input  logic                     i_take,
    input  logic signed [COEF_W-1:0] i_coef,
    input  t_iq                      i_smp,
    output logic signed [RES_W-1:0]  o_acc_i,
    output logic signed [RES_W-1:0]  o_acc_q
);

    logic                     r_prod_vld;
    logic signed [PROD_W-1:0] r_prod_i;
    logic signed [PROD_W-1:0] r_prod_q;
    logic signed [RES_W-1:0]  r_acc_i;
    logic signed [RES_W-1:0]  r_acc_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_take;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod_i <= PROD_W'(i_coef) * PROD_W'(i_smp.i);
        r_prod_q <= PROD_W'(i_coef) * PROD_W'(i_smp.q);
    end

    // The sums wrap at the result width, like the arithmetic they model.
    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_acc_i <= '0;
            r_acc_q <= '0;
        end else if (r_prod_vld) begin
            r_acc_i <= r_acc_i + RES_W'(r_prod_i);
            r_acc_q <= r_acc_q + RES_W'(r_prod_q);
        end
    end

    assign o_acc_i = r_acc_i;
    assign o_acc_q = r_acc_q;

endmodule

// ----- sv/complex_decimating_fir_16bit.sv -----
// Top level of the complex decimating FIR on 16-bit I/Q samples.
// Depends on cdf_pkg, cdf_in_if, cdf_out_if, cdf_sample_cell, cdf_coef_cell, cdf_mac.
//
//   Channel   Direction  Handshake        Carries
//   i_in      in         valid / ready    opcode, coeff_index, coeff_value,
//                                         sample_i, sample_q, block_start
//   o_out     out        valid / ready    result_i, result_q
//   i_cfg_*   in         write enable     tap_count (index 0), decimation (index 1)
//
// A coefficient load or a sample that completes no window leaves the block idle.
// A sample that completes a decimated window starts a sum pass; ST_DONE then
// hands the result to the output register, and ready stays low until then.
// The pass length is set by the coefficient ring, which turns twice around
// to line up with the window and come home.
// Reset clears the fill count, the decimation phase, the sequencer and the
// output valid; coefficients and delay line contents are unknown until written.
// The output register holds a finished result while the input side goes on
// accepting words; only a second result waits for the first to be taken.
module complex_decimating_fir_16bit
    import cdf_pkg::*;
#(
    parameter int MAX_TAPS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    cdf_in_if.sink                i_in,
    cdf_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Width of a tap count up to MAX_TAPS, and of the pass cycle counter.
    localparam int TW = $clog2(MAX_TAPS + 1);
    localparam int NW = $clog2(2 * MAX_TAPS);
    localparam logic [NW-1:0] CNT_LAST = NW'(2 * MAX_TAPS - 1);

    // Configuration registers.
    logic [TAP_CNT_W-1:0] r_tap_count;
    logic [DECIM_W-1:0]   r_decimation;

    // Control state.
    t_state             r_state, n_state;
    logic [NW-1:0]      r_cnt, n_cnt;
    logic [TW-1:0]      r_fill, n_fill;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic               r_out_valid, n_out_valid;

    // Output payload.
    logic signed [RES_W-1:0] r_res_i;
    logic signed [RES_W-1:0] r_res_q;

    logic [TW-1:0]       w_taps;
    logic [DECIM_W-1:0]  w_decim;
    logic                w_accept;
    logic                w_smp_acc;
    logic                w_load_acc;
    logic                w_emit;
    logic [TW-1:0]       w_fill_nx;
    logic [PHASE_W-1:0]  w_phase_nx;
    logic                w_load_out;
    logic [NW:0]         w_cnt_x;
    logic [NW:0]         w_start;
    logic                w_take;
    t_cell_ctl           w_ctl;
    t_iq                 w_new;

    t_iq                      w_smp     [MAX_TAPS];
    logic signed [COEF_W-1:0] w_coef    [MAX_TAPS];
    logic [MAX_TAPS-1:0]      w_coef_we;
    logic signed [RES_W-1:0]  w_acc_i;
    logic signed [RES_W-1:0]  w_acc_q;

    // ------------------------------------------------------------------
    // Configuration writes.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count  <= TAP_CNT_RST;
            r_decimation <= DECIM_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TAP_COUNT:  r_tap_count  <= i_cfg_data[TAP_CNT_W-1:0];
                CFG_DECIMATION: r_decimation <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A zero tap count means one tap, and counts above the cell count saturate.
    always_comb begin
        if (r_tap_count == '0) begin
            w_taps = TW'(1);
        end else if (int'(r_tap_count) > MAX_TAPS) begin
            w_taps = TW'(MAX_TAPS);
        end else begin
            w_taps = TW'(r_tap_count);
        end
    end

    always_comb begin
        if (r_decimation == '0) begin
            w_decim = DECIM_W'(1);
        end else if (r_decimation > DECIM_MAX) begin
            w_decim = DECIM_MAX;
        end else begin
            w_decim = r_decimation;
        end
    end

    // ------------------------------------------------------------------
    // Input handshake and window bookkeeping.
    // ------------------------------------------------------------------
    assign i_in.ready = (r_state == ST_IDLE);
    assign w_accept   = i_in.valid && (r_state == ST_IDLE);
    assign w_smp_acc  = w_accept && (i_in.opcode == OP_SAMPLE);
    assign w_load_acc = w_accept && (i_in.opcode == OP_LOAD);

    // While the window fills, the sample that makes it full starts a result.
    // After that the decimation phase counts samples between results.
    always_comb begin
        logic [TW-1:0]      v_fill;
        logic [PHASE_W-1:0] v_phase;
        logic [DECIM_W-1:0] v_next;

        v_fill  = i_in.block_start ? '0 : r_fill;
        v_phase = i_in.block_start ? '0 : r_phase;
        v_next  = {1'b0, v_phase} + DECIM_W'(1);
        w_emit     = 1'b0;
        w_fill_nx  = v_fill;
        w_phase_nx = v_phase;
        if (v_fill < w_taps) begin
            w_fill_nx = v_fill + TW'(1);
            if (w_fill_nx == w_taps) begin
                w_emit     = 1'b1;
                w_phase_nx = '0;
            end
        end else if (v_next >= w_decim) begin
            w_emit     = 1'b1;
            w_phase_nx = '0;
        end else begin
            w_phase_nx = v_next[PHASE_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Sum pass sequencing.
    // The coefficient ring turns one cell per cycle for the whole pass, twice
    // around, so it ends where it started. The sample ring turns the other way
    // one full turn, starting at w_start, which is chosen so that cell zero
    // then pairs the k-th newest sample with coefficient taps-1-k. Only the
    // first taps of those pairs feed the accumulator.
    // ------------------------------------------------------------------
    assign w_cnt_x = {1'b0, r_cnt};
    assign w_start = (NW+1)'(MAX_TAPS + 1) - (NW+1)'(w_taps);

    assign w_ctl.shift    = w_smp_acc;
    assign w_ctl.rot_coef = (r_state == ST_PASS);
    assign w_ctl.rot_smp  = (r_state == ST_PASS) && (w_cnt_x >= w_start)
                            && (w_cnt_x < w_start + (NW+1)'(MAX_TAPS));
    assign w_take         = (r_state == ST_PASS) && (w_cnt_x >= w_start)
                            && (w_cnt_x <= (NW+1)'(MAX_TAPS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_fill      <= '0;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_fill      <= n_fill;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_fill      = r_fill;
        n_phase     = r_phase;
        n_out_valid = r_out_valid;
        w_load_out  = 1'b0;
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (w_smp_acc) begin
                    n_fill  = w_fill_nx;
                    n_phase = w_phase_nx;
                    if (w_emit) begin
                        n_state = ST_PASS;
                        n_cnt   = '0;
                    end
                end
            end
            ST_PASS: begin
                n_cnt = r_cnt + NW'(1);
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // Wait here only if an earlier result still sits unread.
                if (!r_out_valid || o_out.ready) begin
                    w_load_out  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_res_i <= w_acc_i;
            r_res_q <= w_acc_q;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.result_i = r_res_i;
    assign o_out.result_q = r_res_q;

    // ------------------------------------------------------------------
    // Cell rows.
    // ------------------------------------------------------------------
    assign w_new.i = i_in.sample_i;
    assign w_new.q = i_in.sample_q;

    for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
        assign w_coef_we[j] = w_load_acc && (int'(i_in.coeff_index) == j);

        if (j == 0) begin : g_head
            cdf_sample_cell u_smp (
                .i_clk  (i_clk),
                .i_ctl  (w_ctl),
                .i_prev (w_new),
                .i_next (w_smp[1]),
                .o_smp  (w_smp[0])
            );
            cdf_coef_cell u_coef (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_load       (w_coef_we[0]),
                .i_load_value (i_in.coeff_value),
                .i_prev       (w_coef[MAX_TAPS-1]),
                .o_coef       (w_coef[0])
            );
        end else if (j == MAX_TAPS - 1) begin : g_tail
            cdf_sample_cell u_smp (
                .i_clk  (i_clk),
                .i_ctl  (w_ctl),
                .i_prev (w_smp[j-1]),
                .i_next (w_smp[0]),
                .o_smp  (w_smp[j])
            );
            cdf_coef_cell u_coef (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_load       (w_coef_we[j]),
                .i_load_value (i_in.coeff_value),
                .i_prev       (w_coef[j-1]),
                .o_coef       (w_coef[j])
            );
        end else begin : g_mid
            cdf_sample_cell u_smp (
                .i_clk  (i_clk),
                .i_ctl  (w_ctl),
                .i_prev (w_smp[j-1]),
                .i_next (w_smp[j+1]),
                .o_smp  (w_smp[j])
            );
            cdf_coef_cell u_coef (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_load       (w_coef_we[j]),
                .i_load_value (i_in.coeff_value),
                .i_prev       (w_coef[j-1]),
                .o_coef       (w_coef[j])
            );
        end
    end

    cdf_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (w_smp_acc && w_emit),
        .i_take  (w_take),
        .i_coef  (w_coef[0]),
        .i_smp   (w_smp[0]),
        .o_acc_i (w_acc_i),
        .o_acc_q (w_acc_q)
    );

endmodule
